// ----- hw/rtl/accept_qvalue_parser_core_assert.svh -----
// Assertion macros used by the parser RTL (aqp_parser).
`ifndef ACCEPT_QVALUE_PARSER_CORE_ASSERT_SVH
`define ACCEPT_QVALUE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define AQP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define AQP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/aqp_pkg.sv -----
package aqp_pkg;

    localparam int unsigned MAX_LEN = 4096;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 13;
    localparam int unsigned START_W = 12;
    localparam int unsigned LEN_W   = 13;
    localparam int unsigned Q_W     = 26;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned INT_W   = 30;
    localparam int unsigned FRAC_W  = 10;

    localparam int unsigned OUT_FIELDS_W = STAT_W + START_W + LEN_W + Q_W;
    localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);
    localparam logic [Q_W-1:0]   Q_ONE     = Q_W'(1000);
    localparam logic [INT_W-1:0] INT_SAT   = INT_W'(65535000);

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_Q     = 8'h71;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_Q    = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic              last_byte;
    } t_byte_item;

    typedef struct packed {
        t_status            status;
        logic [START_W-1:0] value_start;
        logic [LEN_W-1:0]   value_length;
        logic [Q_W-1:0]     q_milli;
    } t_result;

endpackage

// ----- hw/rtl/aqp_in_stage.sv -----
module aqp_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  aqp_pkg::t_byte_item i_item,
    input  logic                i_out_free,
    output aqp_pkg::t_byte_item o_item,
    output logic                o_step
);

    logic                r_valid;
    aqp_pkg::t_byte_item r_item;

    // A last byte needs a free result slot; other bytes always advance.
    assign o_step        = r_valid && (!r_item.last_byte || i_out_free);
    assign s_axis_tready = !r_valid || o_step;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_valid <= 1'b1;
        end else if (o_step) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- hw/rtl/aqp_parser.sv -----
`include "accept_qvalue_parser_core_assert.svh"

module aqp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  aqp_pkg::t_byte_item i_item,
    output logic                o_res_valid,
    output aqp_pkg::t_result    o_res
);

    typedef enum logic [3:0] {
        PH_LEAD  = 4'd0,
        PH_VALUE = 4'd1,
        PH_SEMI  = 4'd2,
        PH_EQ    = 4'd3,
        PH_INT   = 4'd4,
        PH_DOT   = 4'd5,
        PH_FRAC  = 4'd6,
        PH_TRAIL = 4'd7,
        PH_DONE  = 4'd8
    } t_phase;

    t_phase                                 r_phase;
    logic [aqp_pkg::POS_W-1:0]              r_position;
    logic [aqp_pkg::START_W-1:0]            r_start_pos;
    logic [aqp_pkg::POS_W-1:0]              r_value_end;
    logic [aqp_pkg::Q_W-1:0]                r_int_milli;
    logic [aqp_pkg::FRAC_W-1:0]             r_frac_milli;
    logic [1:0]                             r_frac_count;
    aqp_pkg::t_status                       r_error;

    t_phase                                 n_phase;
    logic [aqp_pkg::POS_W-1:0]              n_position;
    logic [aqp_pkg::START_W-1:0]            n_start_pos;
    logic [aqp_pkg::POS_W-1:0]              n_value_end;
    logic [aqp_pkg::Q_W-1:0]                n_int_milli;
    logic [aqp_pkg::FRAC_W-1:0]             n_frac_milli;
    logic [1:0]                             n_frac_count;
    aqp_pkg::t_status                       n_error;

    logic [aqp_pkg::BYTE_W-1:0]             w_c;
    logic                                   w_blank;
    logic                                   w_digit_ok;
    logic                                   w_stop;
    logic [3:0]                             w_digit;
    logic [aqp_pkg::INT_W-1:0]              w_int_next;
    logic [aqp_pkg::FRAC_W-1:0]             w_frac_add;
    logic [aqp_pkg::POS_W-1:0]              w_pos_inc;
    aqp_pkg::t_status                       w_final_err;

    assign w_c        = i_item.header_byte;
    assign w_blank    = (w_c == aqp_pkg::CH_SPACE) || (w_c == aqp_pkg::CH_TAB);
    assign w_digit_ok = (w_c >= aqp_pkg::CH_ZERO) && (w_c <= aqp_pkg::CH_NINE);
    assign w_stop     = (w_c == aqp_pkg::CH_COMMA) || (w_c == aqp_pkg::CH_SEMI);
    assign w_digit    = w_c[3:0];
    assign w_pos_inc  = r_position + aqp_pkg::POS_W'(1);

    // Integer part kept in thousandths: x*10 by shift-add, plus digit*1000.
    assign w_int_next = (aqp_pkg::INT_W'(r_int_milli) << 3)
                      + (aqp_pkg::INT_W'(r_int_milli) << 1)
                      + aqp_pkg::INT_W'(14'(w_digit) * 14'd1000);

    always_comb begin
        case (r_frac_count)
            2'd0:    w_frac_add = aqp_pkg::FRAC_W'(w_digit) * 10'd100;
            2'd1:    w_frac_add = aqp_pkg::FRAC_W'(w_digit) * 10'd10;
            2'd2:    w_frac_add = aqp_pkg::FRAC_W'(w_digit);
            default: w_frac_add = '0;
        endcase
    end

    always_comb begin
        logic bad;
        bad          = 1'b0;
        n_phase      = r_phase;
        n_start_pos  = r_start_pos;
        n_value_end  = r_value_end;
        n_int_milli  = r_int_milli;
        n_frac_milli = r_frac_milli;
        n_frac_count = r_frac_count;
        n_error      = r_error;

        case (r_phase)
            PH_LEAD: begin
                if (!w_blank) begin
                    n_start_pos = r_position[aqp_pkg::START_W-1:0];
                    if (w_c == aqp_pkg::CH_SEMI) begin
                        n_value_end = r_position;
                        n_phase     = PH_SEMI;
                    end else begin
                        n_value_end = w_pos_inc;
                        n_phase     = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                if (w_c == aqp_pkg::CH_SEMI) begin
                    n_value_end = r_position;
                    n_phase     = PH_SEMI;
                end else if (!w_blank) begin
                    n_value_end = w_pos_inc;
                end
            end
            PH_SEMI: begin
                if (w_c == aqp_pkg::CH_Q) begin
                    n_phase = PH_EQ;
                end else if (!w_blank) begin
                    bad = 1'b1;
                end
            end
            PH_EQ: begin
                if (w_c == aqp_pkg::CH_EQ) begin
                    n_phase = PH_INT;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_INT: begin
                if (w_digit_ok) begin
                    n_int_milli = (w_int_next > aqp_pkg::INT_SAT)
                                ? aqp_pkg::INT_SAT[aqp_pkg::Q_W-1:0]
                                : w_int_next[aqp_pkg::Q_W-1:0];
                end else if (w_stop) begin
                    n_phase = PH_DONE;
                end else if (w_c == aqp_pkg::CH_DOT) begin
                    n_phase = PH_DOT;
                end else if (w_blank) begin
                    n_phase = PH_TRAIL;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_DOT, PH_FRAC: begin
                if (w_digit_ok) begin
                    n_frac_milli = r_frac_milli + w_frac_add;
                    if (r_frac_count != 2'd3) begin
                        n_frac_count = r_frac_count + 2'd1;
                    end
                    n_phase = PH_FRAC;
                end else if (w_stop) begin
                    n_phase = PH_DONE;
                end else if (w_blank && (r_phase == PH_FRAC)) begin
                    n_phase = PH_TRAIL;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_TRAIL: begin
                if (!w_blank) begin
                    bad = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (bad) begin
            n_phase = PH_DONE;
            if (r_error == aqp_pkg::ST_OK) begin
                n_error = aqp_pkg::ST_BAD_Q;
            end
        end

        // Hold the position once it passes the length limit.
        n_position = (r_position <= aqp_pkg::POS_LIMIT) ? w_pos_inc : r_position;
        if (n_position > aqp_pkg::POS_LIMIT) begin
            n_error = aqp_pkg::ST_TOO_LONG;
        end
    end

    // A dangling "q" or '.' at the end of the element is malformed.
    assign w_final_err = ((n_error == aqp_pkg::ST_OK) &&
                          ((n_phase == PH_EQ) || (n_phase == PH_DOT)))
                       ? aqp_pkg::ST_BAD_Q : n_error;

    always_comb begin
        o_res.status       = w_final_err;
        o_res.value_start  = '0;
        o_res.value_length = '0;
        o_res.q_milli      = '0;
        if (w_final_err == aqp_pkg::ST_OK) begin
            if (n_phase == PH_LEAD) begin
                o_res.q_milli = aqp_pkg::Q_ONE;
            end else begin
                o_res.value_start  = n_start_pos;
                o_res.value_length = n_value_end - aqp_pkg::LEN_W'(n_start_pos);
                if ((n_phase == PH_VALUE) || (n_phase == PH_SEMI)) begin
                    o_res.q_milli = aqp_pkg::Q_ONE;
                end else begin
                    o_res.q_milli = n_int_milli + aqp_pkg::Q_W'(n_frac_milli);
                end
            end
        end
    end

    assign o_res_valid = i_step && i_item.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            r_phase      <= PH_LEAD;
            r_position   <= '0;
            r_start_pos  <= '0;
            r_value_end  <= '0;
            r_int_milli  <= '0;
            r_frac_milli <= '0;
            r_frac_count <= '0;
            r_error      <= aqp_pkg::ST_OK;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_position   <= n_position;
            r_start_pos  <= n_start_pos;
            r_value_end  <= n_value_end;
            r_int_milli  <= n_int_milli;
            r_frac_milli <= n_frac_milli;
            r_frac_count <= n_frac_count;
            r_error      <= n_error;
        end
    end

    `AQP_ASSERT_NEXT(a_restart_after_last, o_res_valid, (r_phase == PH_LEAD) && (r_position == '0), "parser did not restart after last byte")
    `AQP_ASSERT_NOW(a_pos_bounded, 1'b1, r_position <= aqp_pkg::POS_LIMIT + aqp_pkg::POS_W'(1), "position passed its saturation point")
    `AQP_ASSERT_NOW(a_frac_empty, r_frac_count == 2'd0, r_frac_milli == '0, "fraction set without any fraction digit")
    `AQP_ASSERT_NOW(a_err_zero_fields, o_res_valid && (o_res.status != aqp_pkg::ST_OK), (o_res.value_start == '0) && (o_res.value_length == '0) && (o_res.q_milli == '0), "error result carries nonzero fields")

endmodule

// ----- hw/rtl/aqp_out_stage.sv -----
module aqp_out_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  aqp_pkg::t_result                   i_res,
    output logic                               o_free,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [aqp_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic             r_valid;
    aqp_pkg::t_result r_res;

    assign o_free        = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {
        (aqp_pkg::OUT_DATA_W - aqp_pkg::OUT_FIELDS_W)'(0),
        r_res.q_milli, r_res.value_length, r_res.value_start, r_res.status
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- hw/rtl/accept_qvalue_parser_core.sv -----
// Accept-header element parser.
// Input stream: one character per transaction on s_axis_tdata[7:0]; s_axis_tlast
// marks the final character of an element. Each element yields exactly one
// result transaction on the master side, carrying the parse status, where the
// value starts, its length and the quality value in thousandths.
// Throughput: one character per cycle while no final character waits for a free
// result slot, with no gap between elements. Each character passes an input
// register, one pass of the phase machine and running decimal accumulator, and,
// for the last one, the result register, from which the result reaches m_axis.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the
// parser to the start of an element.
// When the receiver stalls, the pending result holds in the output register
// and non-final characters keep flowing in; a final character waits in the
// input register until the result slot frees, and s_axis_tready drops only then.
module accept_qvalue_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] header_byte
    input  logic                           s_axis_tlast,  // last_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] status, [13:2] value_start, [26:14] value_length, [52:27] q_milli
    output logic [aqp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    aqp_pkg::t_byte_item w_in_item;
    aqp_pkg::t_byte_item w_stage_item;
    aqp_pkg::t_result    w_res;
    logic                w_step;
    logic                w_out_free;
    logic                w_res_valid;

    assign w_in_item.header_byte = s_axis_tdata;
    assign w_in_item.last_byte   = s_axis_tlast;

    aqp_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_item        (w_in_item),
        .i_out_free    (w_out_free),
        .o_item        (w_stage_item),
        .o_step        (w_step)
    );

    aqp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (w_stage_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    aqp_out_stage u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_res_valid),
        .i_res         (w_res),
        .o_free        (w_out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- dv/accept_qvalue_parser_core_tb.sv -----
`timescale 1ns / 1ps

module accept_qvalue_parser_core_tb;

    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_BYTES  = 500;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [3:0] {
        P_LEAD, P_VALUE, P_SEMI, P_EQ, P_INT, P_DOT, P_FRAC, P_TRAIL, P_DONE
    } t_parse_phase;

    typedef struct {
        bit               pinned;
        aqp_pkg::t_result res;
    } t_pinned_result;

    typedef struct {
        string          head;
        int             fill_n;
        logic [7:0]     fill_c;
        string          tail;
        t_pinned_result pin;
    } t_element_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata = 8'h00;  // [7:0] header_byte
    logic                           s_axis_tlast = 1'b0;   // last_byte
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [1:0] status, [13:2] value_start, [26:14] value_length, [52:27] q_milli
    logic [aqp_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    accept_qvalue_parser_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Parser state mirror
    t_parse_phase     ph = P_LEAD;
    int               pos = 0;
    int               vstart = 0;
    int               vend = 0;
    int               ipart = 0;
    int               fmilli = 0;
    int               fcount = 0;
    aqp_pkg::t_status err = aqp_pkg::ST_OK;

    t_pinned_result   pinned_results[$];
    aqp_pkg::t_result pending_results[$];
    t_element_row     element_rows[$];
    logic [7:0]       frame_q[$];

    int fault_count = 0;
    int stall_cycles = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    function automatic bit is_blank(input logic [7:0] c);
        return c == aqp_pkg::CH_SPACE || c == aqp_pkg::CH_TAB;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= aqp_pkg::CH_ZERO && c <= aqp_pkg::CH_NINE;
    endfunction

    function automatic void mark_malformed();
        if (err == aqp_pkg::ST_OK) begin
            err = aqp_pkg::ST_BAD_Q;
        end
        ph = P_DONE;
    endfunction

    function automatic void clear_parser();
        ph = P_LEAD;
        pos = 0;
        vstart = 0;
        vend = 0;
        ipart = 0;
        fmilli = 0;
        fcount = 0;
        err = aqp_pkg::ST_OK;
    endfunction

    // Advance the parser by one character; return 1 with the result on the final one.
    function automatic bit parse_qvalue_byte(input logic [7:0] c, input bit last,
                                             output aqp_pkg::t_result r);
        int d;
        int v;
        d = int'(c) - int'(aqp_pkg::CH_ZERO);
        // First non-blank opens the value and is handled as a value character
        if (ph == P_LEAD && !is_blank(c)) begin
            vstart = pos;
            vend = pos;
            ph = P_VALUE;
        end
        case (ph)
            P_VALUE: begin
                if (c == aqp_pkg::CH_SEMI) begin
                    vend = pos;
                    ph = P_SEMI;
                end else if (!is_blank(c)) begin
                    vend = pos + 1;
                end
            end
            P_SEMI: begin
                if (c == aqp_pkg::CH_Q) begin
                    ph = P_EQ;
                end else if (!is_blank(c)) begin
                    mark_malformed();
                end
            end
            P_EQ: begin
                if (c == aqp_pkg::CH_EQ) ph = P_INT;
                else mark_malformed();
            end
            P_INT: begin
                if (is_digit(c)) begin
                    v = ipart * 10 + d;
                    ipart = (v > 65535) ? 65535 : v;
                end else if (c == aqp_pkg::CH_COMMA || c == aqp_pkg::CH_SEMI) begin
                    ph = P_DONE;
                end else if (c == aqp_pkg::CH_DOT) begin
                    ph = P_DOT;
                end else if (is_blank(c)) begin
                    ph = P_TRAIL;
                end else begin
                    mark_malformed();
                end
            end
            P_DOT, P_FRAC: begin
                if (is_digit(c)) begin
                    case (fcount)
                        0: fmilli += d * 100;
                        1: fmilli += d * 10;
                        2: fmilli += d;
                        default: ;
                    endcase
                    if (fcount < 3) fcount++;
                    ph = P_FRAC;
                end else if (c == aqp_pkg::CH_COMMA || c == aqp_pkg::CH_SEMI) begin
                    ph = P_DONE;
                end else if (is_blank(c) && ph == P_FRAC) begin
                    ph = P_TRAIL;
                end else begin
                    mark_malformed();
                end
            end
            P_TRAIL: begin
                if (!is_blank(c)) mark_malformed();
            end
            default: ;
        endcase

        if (pos <= aqp_pkg::MAX_LEN) pos++;
        if (pos > aqp_pkg::MAX_LEN) err = aqp_pkg::ST_TOO_LONG;

        r = '0;
        if (!last) return 1'b0;

        if (err == aqp_pkg::ST_OK && (ph == P_EQ || ph == P_DOT)) err = aqp_pkg::ST_BAD_Q;

        r.status = err;
        if (err == aqp_pkg::ST_OK) begin
            if (ph == P_LEAD) begin
                r.q_milli = aqp_pkg::Q_ONE;
            end else begin
                r.value_start  = aqp_pkg::START_W'(vstart);
                r.value_length = aqp_pkg::LEN_W'(vend - vstart);
                if (ph == P_VALUE || ph == P_SEMI) r.q_milli = aqp_pkg::Q_ONE;
                else r.q_milli = aqp_pkg::Q_W'(ipart * 1000 + fmilli);
            end
        end
        clear_parser();
        return 1'b1;
    endfunction

    function automatic void report_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function automatic void add_row(input string head, input int fill_n,
                                    input logic [7:0] fill_c, input string tail,
                                    input bit pinned, input aqp_pkg::t_status st,
                                    input int vs, input int vl, input int q);
        t_element_row row;
        row.head = head;
        row.fill_n = fill_n;
        row.fill_c = fill_c;
        row.tail = tail;
        row.pin.pinned = pinned;
        row.pin.res.status = st;
        row.pin.res.value_start = aqp_pkg::START_W'(vs);
        row.pin.res.value_length = aqp_pkg::LEN_W'(vl);
        row.pin.res.q_milli = aqp_pkg::Q_W'(q);
        element_rows.push_back(row);
    endfunction

    function automatic void push_blanks(input int n);
        repeat (n) frame_q.push_back($urandom_range(1) ? aqp_pkg::CH_SPACE : aqp_pkg::CH_TAB);
    endfunction

    function automatic void push_digits(input int n);
        repeat (n) frame_q.push_back(aqp_pkg::CH_ZERO + 8'($urandom_range(9)));
    endfunction

    // Bias toward the characters the parser reacts to
    function automatic logic [7:0] rand_char();
        string hot;
        hot = "\t ;,.=q0123456789";
        case ($urandom_range(2))
            0: return 8'($urandom_range(255));
            1: return hot[$urandom_range(hot.len() - 1)];
            default: return "a" + 8'($urandom_range(25));
        endcase
    endfunction

    function automatic void build_well_formed();
        logic [7:0] c;
        string      sym;
        sym = "/*+-";
        frame_q = {};
        push_blanks($urandom_range(3));
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(7))
                0: begin
                    do c = 8'($urandom_range(255));
                    while (c == aqp_pkg::CH_SEMI || is_blank(c));
                end
                1: c = sym[$urandom_range(3)];
                default: c = "a" + 8'($urandom_range(25));
            endcase
            frame_q.push_back(c);
        end
        if ($urandom_range(3) != 0) begin
            push_blanks($urandom_range(2));
            frame_q.push_back(aqp_pkg::CH_SEMI);
            push_blanks($urandom_range(2));
            frame_q.push_back(aqp_pkg::CH_Q);
            frame_q.push_back(aqp_pkg::CH_EQ);
            push_digits($urandom_range(6));
            if ($urandom_range(1)) begin
                frame_q.push_back(aqp_pkg::CH_DOT);
                push_digits($urandom_range(1, 5));
            end
            case ($urandom_range(3))
                1: begin
                    frame_q.push_back(aqp_pkg::CH_COMMA);
                    repeat ($urandom_range(4)) frame_q.push_back(rand_char());
                end
                2: begin
                    frame_q.push_back(aqp_pkg::CH_SEMI);
                    repeat ($urandom_range(4)) frame_q.push_back(rand_char());
                end
                3: push_blanks($urandom_range(1, 2));
                default: ;
            endcase
        end else begin
            push_blanks($urandom_range(2));
        end
    endfunction

    function automatic void build_random_frame();
        int k;
        k = $urandom_range(99);
        if (k < 60) begin
            build_well_formed();
        end else if (k < 85) begin
            build_well_formed();
            if ($urandom_range(1)) begin
                repeat ($urandom_range(1, 2))
                    frame_q[$urandom_range(frame_q.size() - 1)] = rand_char();
            end else begin
                k = $urandom_range(1, frame_q.size());
                while (frame_q.size() > k) void'(frame_q.pop_back());
            end
        end else begin
            frame_q = {};
            repeat ($urandom_range(1, 10)) frame_q.push_back(rand_char());
        end
    endfunction

    task automatic send_frame(input t_pinned_result pin);
        pinned_results.push_back(pin);
        foreach (frame_q[i]) begin
            while ($urandom_range(99) < src_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= frame_q[i];
            s_axis_tlast <= (i == frame_q.size() - 1);
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
        end
    endtask

    // Receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin : scoreboard
        aqp_pkg::t_result got;
        aqp_pkg::t_result want;
        aqp_pkg::t_result seen;
        t_pinned_result   pin;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_qvalue_byte(s_axis_tdata, s_axis_tlast, got)) begin
                    if (pinned_results.size() != 0) pin = pinned_results.pop_front();
                    else pin.pinned = 1'b0;
                    pending_results.push_back(pin.pinned ? pin.res : got);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen.status       = aqp_pkg::t_status'(m_axis_tdata[1:0]);
                seen.value_start  = m_axis_tdata[13:2];
                seen.value_length = m_axis_tdata[26:14];
                seen.q_milli      = m_axis_tdata[52:27];
                if (pending_results.size() == 0) begin
                    report_fault($sformatf(
                        "unexpected result transaction: st=%0d vs=%0d vl=%0d q=%0d",
                        seen.status, seen.value_start, seen.value_length, seen.q_milli));
                end else begin
                    want = pending_results.pop_front();
                    if (seen.status !== want.status || seen.value_start !== want.value_start ||
                        seen.value_length !== want.value_length ||
                        seen.q_milli !== want.q_milli) begin
                        report_fault($sformatf(
                            "exp st=%0d vs=%0d vl=%0d q=%0d got st=%0d vs=%0d vl=%0d q=%0d",
                            want.status, want.value_start, want.value_length, want.q_milli,
                            seen.status, seen.value_start, seen.value_length, seen.q_milli));
                    end
                end
            end
        end
    end

    // Abort when neither side moves a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int             src_pct [4];
        int             snk_pct [4];
        int             sent;
        t_pinned_result none;
        src_pct = '{0, 71, 0, 22};
        snk_pct = '{0, 0, 71, 22};
        none = '{pinned: 1'b0, res: '0};

        // head, fill count, fill char, tail, pinned, status, start, length, q
        add_row(" \t ", 0, " ", "", 1, aqp_pkg::ST_OK, 0, 0, 1000);
        add_row("a", 0, " ", "", 1, aqp_pkg::ST_OK, 0, 1, 1000);
        add_row("  text/html ; q=0.5", 0, " ", "", 0, aqp_pkg::ST_OK, 0, 0, 0);
        add_row("a;q=", 0, " ", "", 1, aqp_pkg::ST_OK, 0, 1, 0);
        add_row("a;q", 0, " ", "", 1, aqp_pkg::ST_BAD_Q, 0, 0, 0);
        add_row("a;q=1.", 0, " ", "", 1, aqp_pkg::ST_BAD_Q, 0, 0, 0);
        add_row("a;q=1. ", 0, " ", "", 1, aqp_pkg::ST_BAD_Q, 0, 0, 0);
        add_row("a;x=1", 0, " ", "", 1, aqp_pkg::ST_BAD_Q, 0, 0, 0);
        add_row("a;q=70000.99999", 0, " ", "", 1, aqp_pkg::ST_OK, 0, 1, 65535999);
        add_row("\377b ;\tq=1,junk", 0, " ", "", 0, aqp_pkg::ST_OK, 0, 0, 0);
        add_row("a;q=0.25 ", 0, " ", "", 0, aqp_pkg::ST_OK, 0, 0, 0);
        add_row("a;q=2 z", 0, " ", "", 1, aqp_pkg::ST_BAD_Q, 0, 0, 0);
        add_row("a;q=3;x", 0, " ", "", 0, aqp_pkg::ST_OK, 0, 0, 0);
        add_row(";", 0, " ", "", 0, aqp_pkg::ST_OK, 0, 0, 0);
        add_row("a;q=.5", 0, " ", "", 0, aqp_pkg::ST_OK, 0, 0, 0);
        add_row("", 4096, "a", "", 1, aqp_pkg::ST_OK, 0, 4096, 1000);
        add_row("", 4095, " ", "x", 1, aqp_pkg::ST_OK, 4095, 1, 1000);
        add_row("", 4097, "b", "", 1, aqp_pkg::ST_TOO_LONG, 0, 0, 0);
        add_row("a;q", 4200, "z", "", 1, aqp_pkg::ST_TOO_LONG, 0, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (element_rows[r]) begin
            frame_q = {};
            for (int i = 0; i < element_rows[r].head.len(); i++)
                frame_q.push_back(element_rows[r].head[i]);
            repeat (element_rows[r].fill_n) frame_q.push_back(element_rows[r].fill_c);
            for (int i = 0; i < element_rows[r].tail.len(); i++)
                frame_q.push_back(element_rows[r].tail[i]);
            send_frame(element_rows[r].pin);
        end

        for (int p = 0; p < 4; p++) begin
            src_idle_pct = src_pct[p];
            snk_stall_pct = snk_pct[p];
            sent = 0;
            while (sent < RANDOM_BYTES) begin
                build_random_frame();
                send_frame(none);
                sent += frame_q.size();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pinned_results.size() != 0 || pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (pending_results.size() != 0) report_fault("result transaction missing at end");
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
